FILE: hdl/p2fb_pkg.sv
// p2fb_pkg: shared types and constants of the packed 2bpp framebuffer engine
// no dependencies; imported by packed_2bpp_framebuffer_engine

package p2fb_pkg;

   // default screen geometry
   localparam int DEF_SCREEN_WIDTH  = 256;
   localparam int DEF_SCREEN_HEIGHT = 128;

   // byte pattern that repeats one colour code over the four slots of a byte
   localparam logic [7:0] FILL_PATTERN = 8'h55;

   // shift of the leftmost pixel slot inside a byte
   localparam logic [2:0] SLOT_TOP_SHIFT = 3'd6;

   // index of the rightmost pixel slot
   localparam logic [1:0] SLOT_LAST = 2'd3;

   typedef enum logic [2:0] {
      KIND_SET_PIXEL = 3'd0,
      KIND_GET_PIXEL = 3'd1,
      KIND_FILL_ALL  = 3'd2,
      KIND_FILL_RECT = 3'd3,
      KIND_READ_ROW  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SET_WR,
      ST_FILL,
      ST_RECT_RD,
      ST_RECT_WR,
      ST_ROW
   } state_type;

endpackage

FILE: hdl/packed_2bpp_framebuffer_engine.sv
// packed_2bpp_framebuffer_engine: 2-bit-per-pixel framebuffer with pixel, fill and row commands
// depends on p2fb_pkg and p2fb_ram
//
//   channel   | ports                                   | handshake
//   ----------+-----------------------------------------+------------------------------
//   request   | req_kind, req_x_pos, req_y_pos,         | taken when start && !busy
//             | req_rect_width, req_rect_height,        |
//             | req_color_in, req_row_index             |
//   response  | rsp_pixel_color, rsp_row_byte,          | each result shown for a single
//             | rsp_last, rsp_in_range                  | cycle by rsp_valid, never held off
//
// set pixel: read then write back of one byte. get pixel: result in the next cycle. fill all:
// one byte written per cycle, starting in the cycle after the accepting one. fill rectangle:
// every touched byte read then written back. read row: one byte read per cycle, starting in
// the cycle after the accepting one; each result appears in the cycle after its read. reset
// only returns control to idle; the store keeps no reset value and needs no clearing pass.
// the result side cannot stall.

module packed_2bpp_framebuffer_engine #(
   parameter int SCREEN_WIDTH  = p2fb_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = p2fb_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_kind,
   input  logic signed [11:0] req_x_pos,
   input  logic signed [11:0] req_y_pos,
   input  logic signed [11:0] req_rect_width,
   input  logic signed [11:0] req_rect_height,
   input  logic [1:0]         req_color_in,
   input  logic [9:0]         req_row_index,
   output logic               rsp_valid,
   output logic [1:0]         rsp_pixel_color,
   output logic [7:0]         rsp_row_byte,
   output logic               rsp_last,
   output logic               rsp_in_range
);

   import p2fb_pkg::*;

   localparam int ROW_BYTES = (SCREEN_WIDTH + 3) / 4;
   localparam int DEPTH     = ROW_BYTES * SCREEN_HEIGHT;
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW        = $clog2(SCREEN_WIDTH);
   localparam int RW        = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
   localparam int BW        = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

   localparam logic signed [12:0] WIDTH_S  = 13'(SCREEN_WIDTH);
   localparam logic signed [12:0] HEIGHT_S = 13'(SCREEN_HEIGHT);

   state_type state_ff, state_in;

   logic [AW-1:0] addr_ff, addr_in;
   logic [1:0]    color_ff, color_in;
   logic [1:0]    slot_ff, slot_in;
   logic [CW-1:0] rect_x0_ff, rect_x0_in;
   logic [CW:0]   rect_x1_ff, rect_x1_in;
   logic [BW-1:0] rect_bx_ff, rect_bx_in;
   logic [BW-1:0] rect_bx_first_ff, rect_bx_first_in;
   logic [BW-1:0] rect_bx_last_ff, rect_bx_last_in;
   logic [RW-1:0] rect_y_ff, rect_y_in;
   logic [RW-1:0] rect_ylast_ff, rect_ylast_in;
   logic [AW-1:0] rect_base_ff, rect_base_in;
   logic [BW-1:0] row_cnt_ff, row_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_is_row_ff, rsp_is_row_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_in_range_ff, rsp_in_range_in;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   kind_type          kind;
   logic              pix_on_screen;
   logic              row_on_screen;
   logic [AW-1:0]     pix_addr;
   logic [AW-1:0]     row_addr;
   logic signed [12:0] clip_x0, clip_x1, clip_y0, clip_y1;
   logic              rect_empty;
   logic [3:0]        set_mask;
   logic [3:0]        rect_mask;
   logic              rect_row_end;
   logic              rect_done;
   logic              row_end;
   logic              fill_end;

   function automatic logic [7:0] merge_pixels(input logic [7:0] old_byte,
                                               input logic [3:0] mask,
                                               input logic [1:0] colour);
      logic [7:0] merged;
      merged = old_byte;
      for (int k = 0; k < 4; k++) begin
         if (mask[k]) begin
            merged[7-2*k -: 2] = colour;
         end
      end
      return merged;
   endfunction

   // ---------------------------------------------------------------- decode
   assign kind = kind_type'(req_kind);

   assign pix_on_screen = !req_x_pos[11] && !req_y_pos[11] &&
                          ($unsigned(req_x_pos) < 12'(SCREEN_WIDTH)) &&
                          ($unsigned(req_y_pos) < 12'(SCREEN_HEIGHT));

   assign row_on_screen = (11'(req_row_index) < 11'(SCREEN_HEIGHT));

   assign pix_addr = AW'($unsigned(req_y_pos)) * AW'(ROW_BYTES) +
                     AW'($unsigned(req_x_pos) >> 2);

   // panel rows count from the bottom
   assign row_addr = (AW'(SCREEN_HEIGHT - 1) - AW'(req_row_index)) * AW'(ROW_BYTES);

   always_comb begin
      clip_x0 = req_x_pos[11] ? 13'sd0 : 13'(req_x_pos);
      clip_y0 = req_y_pos[11] ? 13'sd0 : 13'(req_y_pos);
      clip_x1 = 13'(req_x_pos) + 13'(req_rect_width);
      clip_y1 = 13'(req_y_pos) + 13'(req_rect_height);
      if (clip_x1 > WIDTH_S) begin
         clip_x1 = WIDTH_S;
      end
      if (clip_y1 > HEIGHT_S) begin
         clip_y1 = HEIGHT_S;
      end
   end

   assign rect_empty = (clip_x1 <= clip_x0) || (clip_y1 <= clip_y0);

   assign set_mask = 4'b0001 << slot_ff;

   always_comb begin
      logic [CW:0] col;
      for (int k = 0; k < 4; k++) begin
         col = (CW+1)'({rect_bx_ff, 2'(k)});
         rect_mask[k] = (col >= (CW+1)'(rect_x0_ff)) && (col < rect_x1_ff);
      end
   end

   assign rect_row_end = (rect_bx_ff == rect_bx_last_ff);
   assign rect_done    = rect_row_end && (rect_y_ff == rect_ylast_ff);
   assign row_end      = (row_cnt_ff == BW'(ROW_BYTES - 1));
   assign fill_end     = (addr_ff == AW'(DEPTH - 1));

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (kind)
                  KIND_SET_PIXEL: if (pix_on_screen) state_in = ST_SET_WR;
                  KIND_GET_PIXEL: state_in = ST_IDLE;
                  KIND_FILL_ALL:  state_in = ST_FILL;
                  KIND_FILL_RECT: if (!rect_empty) state_in = ST_RECT_RD;
                  KIND_READ_ROW:  if (row_on_screen) state_in = ST_ROW;
                  default:        state_in = ST_IDLE;
               endcase
            end
         end
         ST_SET_WR:  state_in = ST_IDLE;
         ST_FILL:    if (fill_end) state_in = ST_IDLE;
         ST_RECT_RD: state_in = ST_RECT_WR;
         ST_RECT_WR: state_in = rect_done ? ST_IDLE : ST_RECT_RD;
         ST_ROW:     if (row_end) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      addr_in          = addr_ff;
      color_in         = color_ff;
      slot_in          = slot_ff;
      rect_x0_in       = rect_x0_ff;
      rect_x1_in       = rect_x1_ff;
      rect_bx_in       = rect_bx_ff;
      rect_bx_first_in = rect_bx_first_ff;
      rect_bx_last_in  = rect_bx_last_ff;
      rect_y_in        = rect_y_ff;
      rect_ylast_in    = rect_ylast_ff;
      rect_base_in     = rect_base_ff;
      row_cnt_in       = row_cnt_ff;
      rsp_valid_in     = 1'b0;
      rsp_is_row_in    = rsp_is_row_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_in_range_in  = rsp_in_range_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = addr_ff;
      ram_wr_data      = merge_pixels(ram_rd_data, set_mask, color_ff);
      ram_rd_en        = 1'b0;
      ram_rd_addr      = pix_addr;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               color_in = req_color_in;
               slot_in  = req_x_pos[1:0];
               unique case (kind)
                  KIND_SET_PIXEL: begin
                     addr_in   = pix_addr;
                     ram_rd_en = pix_on_screen;
                  end
                  KIND_GET_PIXEL: begin
                     ram_rd_en       = pix_on_screen;
                     rsp_valid_in    = 1'b1;
                     rsp_is_row_in   = 1'b0;
                     rsp_last_in     = 1'b1;
                     rsp_in_range_in = pix_on_screen;
                  end
                  KIND_FILL_ALL: begin
                     addr_in = '0;
                  end
                  KIND_FILL_RECT: begin
                     rect_x0_in       = clip_x0[CW-1:0];
                     rect_x1_in       = clip_x1[CW:0];
                     rect_bx_in       = BW'(clip_x0 >> 2);
                     rect_bx_first_in = BW'(clip_x0 >> 2);
                     rect_bx_last_in  = BW'((clip_x1 - 13'sd1) >> 2);
                     rect_y_in        = RW'(clip_y0);
                     rect_ylast_in    = RW'(clip_y1 - 13'sd1);
                     rect_base_in     = AW'(clip_y0) * AW'(ROW_BYTES);
                  end
                  KIND_READ_ROW: begin
                     addr_in    = row_addr;
                     row_cnt_in = '0;
                     if (!row_on_screen) begin
                        rsp_valid_in    = 1'b1;
                        rsp_is_row_in   = 1'b1;
                        rsp_last_in     = 1'b1;
                        rsp_in_range_in = 1'b0;
                     end
                  end
                  default: begin
                     addr_in = addr_ff;
                  end
               endcase
            end
         end
         ST_SET_WR: begin
            ram_wr_en = 1'b1;
         end
         ST_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = 8'(color_ff * FILL_PATTERN);
            addr_in     = addr_ff + AW'(1);
         end
         ST_RECT_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = rect_base_ff + AW'(rect_bx_ff);
            addr_in     = rect_base_ff + AW'(rect_bx_ff);
         end
         ST_RECT_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = merge_pixels(ram_rd_data, rect_mask, color_ff);
            if (!rect_row_end) begin
               rect_bx_in = rect_bx_ff + BW'(1);
            end else begin
               rect_bx_in   = rect_bx_first_ff;
               rect_y_in    = rect_y_ff + RW'(1);
               rect_base_in = rect_base_ff + AW'(ROW_BYTES);
            end
         end
         ST_ROW: begin
            ram_rd_en       = 1'b1;
            ram_rd_addr     = addr_ff;
            addr_in         = addr_ff + AW'(1);
            row_cnt_in      = row_cnt_ff + BW'(1);
            rsp_valid_in    = 1'b1;
            rsp_is_row_in   = 1'b1;
            rsp_last_in     = row_end;
            rsp_in_range_in = 1'b1;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff          <= addr_in;
      color_ff         <= color_in;
      slot_ff          <= slot_in;
      rect_x0_ff       <= rect_x0_in;
      rect_x1_ff       <= rect_x1_in;
      rect_bx_ff       <= rect_bx_in;
      rect_bx_first_ff <= rect_bx_first_in;
      rect_bx_last_ff  <= rect_bx_last_in;
      rect_y_ff        <= rect_y_in;
      rect_ylast_ff    <= rect_ylast_in;
      rect_base_ff     <= rect_base_in;
      row_cnt_ff       <= row_cnt_in;
      rsp_is_row_ff    <= rsp_is_row_in;
      rsp_last_ff      <= rsp_last_in;
      rsp_in_range_ff  <= rsp_in_range_in;
   end

   // ---------------------------------------------------------------- store
   p2fb_ram #(
      .DATA_W (8),
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- outputs
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_in_range    = rsp_in_range_ff;
   assign rsp_row_byte    = (rsp_is_row_ff && rsp_in_range_ff) ? ram_rd_data : 8'd0;
   // leftmost pixel lives in the top bits
   assign rsp_pixel_color = (!rsp_is_row_ff && rsp_in_range_ff) ?
                            2'(ram_rd_data >> (SLOT_TOP_SHIFT - {slot_ff, 1'b0})) : 2'd0;

   // ---------------------------------------------------------------- assertions
   a_set_follows_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SET_WR |-> $past(state_ff) == ST_IDLE)
      else $error("set write-back without a preceding read");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && ram_rd_en |-> ram_wr_addr != ram_rd_addr)
      else $error("store read and write collide on one address");

   a_off_screen_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_last)
      else $error("off-screen result not marked last");

   a_rect_in_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RECT_WR |->
         rect_bx_ff <= rect_bx_last_ff && rect_y_ff <= rect_ylast_ff && rect_mask != 4'b0000)
      else $error("rectangle walk left its clipped bounds");

   a_row_read_gives_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROW |=> rsp_valid && rsp_in_range)
      else $error("row read without its result");

   a_last_ends_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && rsp_is_row_ff && rsp_in_range |-> state_ff == ST_IDLE)
      else $error("row walk still running after its last byte");

endmodule

FILE: hdl/p2fb_ram.sv
// p2fb_ram: generic single-clock RAM, one write port and one registered read port
// no dependencies

module p2fb_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 8192,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
